// ===== design/sliding_window_median_unit_defines.svh =====
// Assertion macros shared by the sliding window median design.
// Each use expands to one concurrent assertion clocked on i_clk and
// disabled while i_rst_n is low.
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swm: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swm: assertion failed");
`else
`define SWM_ASSERT_SAME(lbl, ante, cons)
`define SWM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/swm_pkg.sv =====
package swm_pkg;

    localparam int DATA_BITS = 8;
    localparam int CFG_BITS = 9;
    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 9'd3;

    typedef enum logic [1:0] {
        TREE_ADD,
        TREE_SUB,
        TREE_SEARCH
    } t_tree_op;

    typedef struct packed {
        logic     clear;
        logic     start;
        t_tree_op op;
    } t_tree_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_tree_stat;

    typedef struct packed {
        logic restart;
        logic push;
        logic pop;
    } t_line_ctrl;

endpackage

// ===== design/swm_line.sv =====
module swm_line import swm_pkg::*; #(
    parameter int SAMPLE_BITS = 8,
    parameter int MAX_WINDOW = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_line_ctrl                           i_ctrl,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]      i_window,
    output logic                                 o_full,
    output logic [SAMPLE_BITS-1:0]               o_oldest
);

    localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
    localparam int PTR_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_BITS = CNT_BITS + 1;
    localparam logic [SUM_BITS-1:0] DEPTH = SUM_BITS'(MAX_WINDOW);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(MAX_WINDOW - 1);

    logic [SAMPLE_BITS-1:0] r_line_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_oldest_data;
    logic [PTR_BITS-1:0]    r_oldest;
    logic [CNT_BITS-1:0]    r_fill;

    logic [SUM_BITS-1:0] wr_sum;
    logic [SUM_BITS-1:0] wr_pos;
    logic [PTR_BITS-1:0] wr_idx;
    logic [PTR_BITS-1:0] n_oldest;

    // The newest item goes fill_count places after the oldest, wrapping once.
    assign wr_sum = SUM_BITS'(r_oldest) + SUM_BITS'(r_fill);
    assign wr_pos = (wr_sum >= DEPTH) ? (wr_sum - DEPTH) : wr_sum;
    assign wr_idx = wr_pos[PTR_BITS-1:0];
    assign n_oldest = (r_oldest == LAST_PTR) ? '0 : (r_oldest + PTR_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_line_mem[wr_idx] <= i_sample;
        end
        r_oldest_data <= r_line_mem[r_oldest];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.restart) begin
            r_oldest <= '0;
            r_fill <= '0;
        end else if (i_ctrl.push) begin
            r_fill <= r_fill + CNT_BITS'(1);
        end else if (i_ctrl.pop) begin
            r_fill <= r_fill - CNT_BITS'(1);
            r_oldest <= n_oldest;
        end
    end

    assign o_full = (r_fill >= i_window);
    assign o_oldest = r_oldest_data;

endmodule

// ===== design/swm_tree.sv =====
module swm_tree import swm_pkg::*; #(
    parameter int SAMPLE_BITS = 8,
    parameter int CNT_BITS = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tree_cmd              i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_value,
    input  logic [CNT_BITS-1:0]    i_rank,
    output t_tree_stat             o_stat,
    output logic [SAMPLE_BITS-1:0] o_result
);

    localparam int VALUE_COUNT = 1 << SAMPLE_BITS;
    localparam int NODE_BITS = SAMPLE_BITS + 1;
    localparam int WIDE_BITS = SAMPLE_BITS + 2;
    localparam logic [NODE_BITS-1:0] NODE_TOP = {1'b1, {SAMPLE_BITS{1'b0}}};

    typedef enum logic [1:0] {
        T_CLEAR,
        T_IDLE,
        T_RD,
        T_OP
    } t_state;

    t_state                 r_state;
    t_tree_op               r_op;
    logic [NODE_BITS-1:0]   r_node;
    logic [NODE_BITS-1:0]   r_pos;
    logic [NODE_BITS-1:0]   r_step;
    logic [CNT_BITS-1:0]    r_rank;
    logic [SAMPLE_BITS-1:0] r_clr;
    logic                   r_done;
    logic [SAMPLE_BITS-1:0] r_result;

    logic [CNT_BITS-1:0]    r_count_mem [VALUE_COUNT];
    logic [CNT_BITS-1:0]    r_rd_data;

    logic                   is_search;
    logic [WIDE_BITS-1:0]   cur_sum;
    logic                   search_in;
    logic                   take;
    logic [NODE_BITS-1:0]   n_pos;
    logic [CNT_BITS-1:0]    n_rank;
    logic [NODE_BITS-1:0]   step_half;
    logic [WIDE_BITS-1:0]   next_sum;
    logic [NODE_BITS-1:0]   low_bit;
    logic [WIDE_BITS-1:0]   node_next;
    logic                   node_end;
    logic [CNT_BITS-1:0]    adj_data;
    logic [WIDE_BITS-1:0]   rd_node;
    logic [WIDE_BITS-1:0]   rd_tmp;
    logic [SAMPLE_BITS-1:0] rd_addr;
    logic [WIDE_BITS-1:0]   wr_tmp;
    logic                   wr_en;
    logic [SAMPLE_BITS-1:0] wr_addr;
    logic [CNT_BITS-1:0]    wr_data;
    logic [SAMPLE_BITS-1:0] capped;

    assign is_search = (r_op == TREE_SEARCH);

    // Binary descent: probe node pos + step, take it while its count is below the rank.
    assign cur_sum = WIDE_BITS'(r_pos) + WIDE_BITS'(r_step);
    assign search_in = (cur_sum <= WIDE_BITS'(NODE_TOP));
    assign take = search_in && (r_rd_data < r_rank);
    assign n_pos = take ? cur_sum[NODE_BITS-1:0] : r_pos;
    assign n_rank = take ? (r_rank - r_rd_data) : r_rank;
    assign step_half = r_step >> 1;
    assign next_sum = WIDE_BITS'(n_pos) + WIDE_BITS'(step_half);
    assign capped = n_pos[SAMPLE_BITS] ? '1 : n_pos[SAMPLE_BITS-1:0];

    // Count update walks up the tree by adding the lowest set bit of the node.
    assign low_bit = r_node & (~r_node + NODE_BITS'(1));
    assign node_next = WIDE_BITS'(r_node) + WIDE_BITS'(low_bit);
    assign node_end = (node_next > WIDE_BITS'(NODE_TOP));
    assign adj_data = (r_op == TREE_ADD) ? (r_rd_data + CNT_BITS'(1))
                                         : (r_rd_data - CNT_BITS'(1));

    // Node n is stored at address n - 1. Each cycle of T_OP reads the next node
    // while an update walk writes the current one; along an update walk the nodes strictly grow.
    always_comb begin
        case (r_state)
            T_RD:    rd_node = is_search ? cur_sum : WIDE_BITS'(r_node);
            T_OP:    rd_node = is_search ? next_sum : node_next;
            default: rd_node = '0;
        endcase
    end
    assign rd_tmp = rd_node - WIDE_BITS'(1);
    assign rd_addr = rd_tmp[SAMPLE_BITS-1:0];

    assign wr_tmp = WIDE_BITS'(r_node) - WIDE_BITS'(1);
    always_comb begin
        case (r_state)
            T_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
            end
            T_OP: begin
                wr_en = !is_search;
                wr_addr = wr_tmp[SAMPLE_BITS-1:0];
                wr_data = adj_data;
            end
            default: begin
                wr_en = 1'b0;
                wr_addr = wr_tmp[SAMPLE_BITS-1:0];
                wr_data = adj_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_count_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_count_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_state <= T_CLEAR;
            r_clr <= '0;
            r_done <= 1'b0;
            r_op <= TREE_ADD;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                T_CLEAR: begin
                    r_clr <= r_clr + SAMPLE_BITS'(1);
                    if (r_clr == {SAMPLE_BITS{1'b1}}) begin
                        r_state <= T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (i_cmd.start) begin
                        r_op <= i_cmd.op;
                        r_node <= NODE_BITS'(i_value) + NODE_BITS'(1);
                        r_pos <= '0;
                        r_step <= NODE_TOP;
                        r_rank <= i_rank;
                        r_state <= T_RD;
                    end
                end
                T_RD: begin
                    r_state <= T_OP;
                end
                T_OP: begin
                    if (is_search) begin
                        r_pos <= n_pos;
                        r_rank <= n_rank;
                        r_step <= step_half;
                        if (r_step == NODE_BITS'(1)) begin
                            r_result <= capped;
                            r_done <= 1'b1;
                            r_state <= T_IDLE;
                        end
                    end else begin
                        r_node <= node_next[NODE_BITS-1:0];
                        if (node_end) begin
                            r_done <= 1'b1;
                            r_state <= T_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state != T_IDLE);
    assign o_stat.done = r_done;
    assign o_result = r_result;

endmodule

// ===== design/sliding_window_median_unit.sv =====
// Moving lower-median filter over unsigned samples.
// Input items arrive on s_tvalid / s_tready / s_tdata, results leave on
// m_tvalid / m_tready / m_tdata; an item moves when tvalid and tready are high
// at a rising edge. The window size is written through i_cfg_we / i_cfg_wdata;
// the user must write it only while the block is idle; the block itself does not
// enforce this. A write restarts the window and clears the counts. Per value
// counts live in a synchronous memory organized as a Fenwick tree. An item
// that completes the window runs three walks over it: add the new sample,
// descend over the value bits to the lower median, remove the oldest sample.
// An item that only fills the window runs the add walk alone.
// After reset and after each window size write a clearing pass zeroes the
// count memory; s_tready is low meanwhile.
// The result sits in an output register. If the receiver stalls, the block
// still takes one more item and runs it up to its median, then holds it with
// s_tready low until the output register is free.
`include "sliding_window_median_unit_defines.svh"

module sliding_window_median_unit import swm_pkg::*; #(
    parameter int SAMPLE_BITS = 8,
    parameter int MAX_WINDOW = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_BITS-1:0]  i_cfg_wdata,   // window_size [8:0]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_BITS-1:0] s_tdata,       // sample [7:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_BITS-1:0] m_tdata        // median [7:0]
);

    localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
    localparam int CMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
    localparam logic [CMP_BITS-1:0] MAX_EXT = CMP_BITS'(MAX_WINDOW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SEARCH,
        S_EMIT,
        S_SUB
    } t_state;

    t_state                r_state;
    logic [CFG_BITS-1:0]   r_window_size;
    logic                  r_out_valid;
    logic [DATA_BITS-1:0]  r_out_data;

    logic [CMP_BITS-1:0]    ws_ext;
    logic [CMP_BITS-1:0]    win_ext;
    logic [CNT_BITS-1:0]    win_eff;
    logic [CNT_BITS-1:0]    rank;
    logic [SAMPLE_BITS+DATA_BITS-1:0] in_ext;
    logic [SAMPLE_BITS+DATA_BITS-1:0] out_ext;
    logic [SAMPLE_BITS-1:0] sample_val;
    logic [SAMPLE_BITS-1:0] oldest_val;
    logic [SAMPLE_BITS-1:0] tree_result;
    logic                   line_full;
    logic                   s_accept;
    logic                   emit_go;
    t_tree_cmd              tree_cmd;
    t_tree_stat             tree_stat;
    logic [SAMPLE_BITS-1:0] tree_value;
    t_line_ctrl             line_ctrl;

    // A size of zero acts as one; sizes above the delay line saturate.
    assign ws_ext = CMP_BITS'(r_window_size);
    assign win_ext = (ws_ext == '0) ? CMP_BITS'(1) : ((ws_ext > MAX_EXT) ? MAX_EXT : ws_ext);
    assign win_eff = win_ext[CNT_BITS-1:0];
    assign rank = (win_eff >> 1) + CNT_BITS'(win_eff[0]);

    assign in_ext = {{SAMPLE_BITS{1'b0}}, s_tdata};
    assign sample_val = in_ext[SAMPLE_BITS-1:0];
    assign out_ext = {{DATA_BITS{1'b0}}, tree_result};

    assign s_tready = (r_state == S_IDLE) && !tree_stat.busy;
    assign s_accept = s_tvalid && s_tready;
    assign emit_go = (r_state == S_EMIT) && (!r_out_valid || m_tready);

    always_comb begin
        tree_cmd.clear = i_cfg_we;
        tree_cmd.start = s_accept || emit_go
                         || ((r_state == S_ADD) && tree_stat.done && line_full);
        case (r_state)
            S_IDLE:  tree_cmd.op = TREE_ADD;
            S_ADD:   tree_cmd.op = TREE_SEARCH;
            default: tree_cmd.op = TREE_SUB;
        endcase
    end
    assign tree_value = (r_state == S_IDLE) ? sample_val : oldest_val;

    assign line_ctrl.restart = i_cfg_we;
    assign line_ctrl.push = s_accept;
    assign line_ctrl.pop = emit_go;

    swm_tree #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tree_cmd),
        .i_value (tree_value),
        .i_rank  (rank),
        .o_stat  (tree_stat),
        .o_result(tree_result)
    );

    swm_line #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (line_ctrl),
        .i_sample(sample_val),
        .i_window(win_eff),
        .o_full  (line_full),
        .o_oldest(oldest_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_window_size <= WINDOW_SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
                r_out_data <= out_ext[DATA_BITS-1:0];
            end
            if (i_cfg_we) begin
                r_window_size <= i_cfg_wdata;
                r_state <= S_IDLE;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (s_accept) begin
                            r_state <= S_ADD;
                        end
                    end
                    S_ADD: begin
                        if (tree_stat.done) begin
                            r_state <= line_full ? S_SEARCH : S_IDLE;
                        end
                    end
                    S_SEARCH: begin
                        if (tree_stat.done) begin
                            r_state <= S_EMIT;
                        end
                    end
                    S_EMIT: begin
                        if (emit_go) begin
                            r_state <= S_SUB;
                        end
                    end
                    S_SUB: begin
                        if (tree_stat.done) begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata = r_out_data;

    // A finished walk is only ever reported while the sequencer waits for one.
    `SWM_ASSERT_SAME(a_done_while_waiting, tree_stat.done, (r_state == S_ADD) || (r_state == S_SEARCH) || (r_state == S_SUB))
    // The median is only searched for once the window holds enough items.
    `SWM_ASSERT_SAME(a_search_needs_full, r_state == S_SEARCH, line_full)
    // Handing a result over always leaves it visible on the output.
    `SWM_ASSERT_NEXT(a_emit_shows_result, emit_go && !i_cfg_we, m_tvalid)

endmodule

// ===== dv/tb_sliding_window_median_unit.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_median_unit;
    import swm_pkg::*;

    localparam int VALUE_COUNT = 1 << DATA_BITS;
    localparam int MAX_SPAN = 256;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_BITS-1:0]   value;
        bit                    typed;
        logic [DATA_BITS-1:0]  median;
    } t_plan_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_BITS-1:0]  i_cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_BITS-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_BITS-1:0] m_tdata;

    // Predictor state: register copy, value histogram and the window contents.
    logic [CFG_BITS-1:0]  window_reg;
    int unsigned          value_hist [VALUE_COUNT];
    logic [DATA_BITS-1:0] window_samples [$];
    logic [DATA_BITS-1:0] pending_medians [$];

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    // Window sizes: reset value first, then one, zero (acts as one), two and four.
    t_plan_row plan [0:22] = '{
        '{ROW_ITEM, 9'd0,   1'b0, 8'd0},
        '{ROW_ITEM, 9'd255, 1'b0, 8'd0},
        '{ROW_ITEM, 9'd128, 1'b1, 8'd128},
        '{ROW_ITEM, 9'd255, 1'b1, 8'd255},
        '{ROW_ITEM, 9'd0,   1'b1, 8'd128},
        '{ROW_ITEM, 9'd1,   1'b0, 8'd0},
        '{ROW_CFG,  9'd1,   1'b0, 8'd0},
        '{ROW_ITEM, 9'd7,   1'b1, 8'd7},
        '{ROW_ITEM, 9'd200, 1'b1, 8'd200},
        '{ROW_CFG,  9'd0,   1'b0, 8'd0},
        '{ROW_ITEM, 9'd255, 1'b1, 8'd255},
        '{ROW_ITEM, 9'd0,   1'b1, 8'd0},
        '{ROW_CFG,  9'd2,   1'b0, 8'd0},
        '{ROW_ITEM, 9'd10,  1'b0, 8'd0},
        '{ROW_ITEM, 9'd20,  1'b1, 8'd10},
        '{ROW_ITEM, 9'd5,   1'b0, 8'd0},
        '{ROW_ITEM, 9'd255, 1'b0, 8'd0},
        '{ROW_CFG,  9'd4,   1'b0, 8'd0},
        '{ROW_ITEM, 9'd170, 1'b0, 8'd0},
        '{ROW_ITEM, 9'd85,  1'b0, 8'd0},
        '{ROW_ITEM, 9'd85,  1'b0, 8'd0},
        '{ROW_ITEM, 9'd170, 1'b0, 8'd0},
        '{ROW_ITEM, 9'd255, 1'b0, 8'd0}
    };

    sliding_window_median_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic void clear_window();
        foreach (value_hist[v]) value_hist[v] = 0;
        window_samples.delete();
    endfunction

    // Adds a sample; once the window is full, returns the lower median and
    // retires the oldest sample.
    function automatic bit window_step(input logic [DATA_BITS-1:0] sample,
                                       output logic [DATA_BITS-1:0] median);
        int unsigned span;
        int unsigned rank;
        int unsigned acc;
        logic [DATA_BITS-1:0] oldest;
        span = (window_reg == 0) ? 1 : ((window_reg > MAX_SPAN) ? MAX_SPAN : window_reg);
        median = '0;
        value_hist[sample]++;
        window_samples = {window_samples, sample};
        if (window_samples.size() < span) return 1'b0;
        rank = (span + 1) / 2;
        acc = 0;
        for (int v = 0; v < VALUE_COUNT; v++) begin
            acc += value_hist[v];
            if (acc >= rank) begin
                median = DATA_BITS'(v);
                break;
            end
        end
        oldest = window_samples.pop_front();
        value_hist[oldest]--;
        return 1'b1;
    endfunction

    // Mix of full-range values, edge values and a narrow band that forces ties.
    function automatic logic [DATA_BITS-1:0] random_sample();
        logic [DATA_BITS-1:0] pick;
        case ($urandom_range(2))
            0: pick = DATA_BITS'($urandom_range(255));
            1: begin
                case ($urandom_range(3))
                    0: pick = 8'd0;
                    1: pick = 8'd1;
                    2: pick = 8'd254;
                    default: pick = 8'd255;
                endcase
            end
            default: pick = DATA_BITS'(120 + $urandom_range(15));
        endcase
        return pick;
    endfunction

    task automatic offer_sample(input logic [DATA_BITS-1:0] value, input bit typed,
                                input logic [DATA_BITS-1:0] typed_median);
        logic [DATA_BITS-1:0] med;
        while (int'($urandom_range(99)) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do @(posedge i_clk); while (!s_tready);
        if (window_step(value, med)) begin
            pending_medians = {pending_medians, (typed ? typed_median : med)};
        end
    endtask

    task automatic drain_results(input int settle);
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_medians.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // An item that gives no result may still be in flight once the queue is
    // empty, so the drain also lets a full item time pass.
    task automatic write_window(input logic [CFG_BITS-1:0] value);
        drain_results(50);
        while (!s_tready) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        window_reg = value;
        clear_window();
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] size, input int items,
                             input int send_pct, input int recv_pct, input int hold);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        write_window(size);
        hold_request = hold;
        repeat (items) offer_sample(random_sample(), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        logic [DATA_BITS-1:0] want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_medians.size() == 0) begin
                $error("median: expected no item, actual %0d", m_tdata);
                mismatches++;
            end else begin
                want = pending_medians.pop_front();
                if (m_tdata !== want) begin
                    $error("median: expected %0d, actual %0d", want, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        window_reg = WINDOW_SIZE_RESET;
        clear_window();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) write_window(plan[i].value);
            else offer_sample(plan[i].value[DATA_BITS-1:0], plan[i].typed, plan[i].median);
        end

        run_phase(9'd5, 60, 0, 0, 0);
        run_phase(9'd1, 60, 60, 0, 0);
        // Oversized setting saturates to the largest window.
        run_phase(9'd511, 262, 30, 30, 0);
        run_phase(CFG_BITS'($urandom_range(20, 2)), 80, 0, 60, 0);
        // Receiver holds off while items keep coming, so the input backs up.
        run_phase(WINDOW_SIZE_RESET, 80, 0, 0, 300);
        run_phase(CFG_BITS'($urandom_range(9, 1)), 60, 30, 30, 0);

        drain_results(60);
        if (pending_medians.size() != 0) begin
            $error("median: expected %0d more items, actual none", pending_medians.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
